/* design/asfrm_pkg.sv */
package asfrm_pkg;

    localparam int DEPTH_DEFAULT = 65536;

    localparam int SAMPLE_W  = 16;
    localparam int FILL_W    = 17;
    localparam int SUM_W     = 47;
    localparam int THR_W     = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 32;
    localparam int QUOT_W    = 31;
    localparam int ROOT_W    = 16;
    localparam int CAP_RESET = 65536;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] fill;
    } t_rms_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [ROOT_W-1:0] root;
    } t_rms_res;

endpackage

/* design/asfrm_rms.sv */
// Mean of squares by restoring division, one quotient bit a cycle, then an
// integer square root, one result bit a cycle.
module asfrm_rms (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asfrm_pkg::t_rms_req i_req,
    output asfrm_pkg::t_rms_res o_res
);

    localparam int QW    = asfrm_pkg::QUOT_W;
    localparam int FW    = asfrm_pkg::FILL_W;
    localparam int SW    = asfrm_pkg::SUM_W;
    localparam int RW    = QW + 1;
    localparam int CNT_W = $clog2(QW);
    localparam int SQRT_STEPS = (QW + 1) / 2;
    localparam logic [RW-1:0] BIT_INIT = RW'(1) << (QW - 1);

    typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} t_ustate;

    t_ustate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [FW-1:0]    r_rem;
    logic [FW-1:0]    r_div;
    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_quot;
    logic [RW-1:0]    r_x;
    logic [RW-1:0]    r_root;
    logic [RW-1:0]    r_bit;
    logic             r_done;

    logic [FW:0]      w_trial;
    logic             w_ge;
    logic [RW-1:0]    w_cand;
    logic             w_take;

    always_comb begin
        w_trial = {r_rem, r_dvd[QW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_cand  = r_root + r_bit;
        w_take  = (r_x >= w_cand);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_div   <= '0;
            r_dvd   <= '0;
            r_quot  <= '0;
            r_x     <= '0;
            r_root  <= '0;
            r_bit   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        // the high part is below the divisor since the mean fits QW bits
                        r_rem   <= {1'b0, i_req.sum[SW-1:QW]};
                        r_dvd   <= i_req.sum[QW-1:0];
                        r_div   <= i_req.fill;
                        r_quot  <= '0;
                        r_cnt   <= CNT_W'(QW - 1);
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    r_rem  <= w_ge ? FW'(w_trial - {1'b0, r_div}) : w_trial[FW-1:0];
                    r_dvd  <= {r_dvd[QW-2:0], 1'b0};
                    r_quot <= {r_quot[QW-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_x     <= {1'b0, r_quot[QW-2:0], w_ge};
                        r_root  <= '0;
                        r_bit   <= BIT_INIT;
                        r_cnt   <= CNT_W'(SQRT_STEPS - 1);
                        r_state <= U_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                U_SQRT: begin
                    if (w_take) begin
                        r_x    <= r_x - w_cand;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.root = r_root[asfrm_pkg::ROOT_W-1:0];

endmodule

/* design/audio_sample_fifo_with_rms_meter.sv */
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_command, i_sample_in, i_offset
// result    out        o_out_valid / i_out_stall o_sample_out, o_sample_valid, o_accepted,
//                                                o_fill_level, o_rms_level, o_silent,
//                                                o_pushed_count, o_popped_count
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One transaction at a time. Clear, empty measure, unknown commands, refused push, empty
// pop and a peek past the held samples go straight to the result; a stored push adds a
// sum update, a hitting peek a store read, and a pop both (store read, square, sum
// update). Measure waits for the bit-serial division of the sum of squares by the fill,
// then the bit-serial square root. The result register frees the input side, so a new
// transaction is taken while the previous result waits on i_out_stall.
// Reset (synchronous, active low) clears indices, fill, sum, totals and registers;
// the sample store itself is not cleared, only held samples are ever read.
module audio_sample_fifo_with_rms_meter #(
    parameter int DEPTH = asfrm_pkg::DEPTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input transactions
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [asfrm_pkg::CMD_W-1:0]           i_command,
    input  logic signed [asfrm_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [asfrm_pkg::SAMPLE_W-1:0]        i_offset,
    // result transactions
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [asfrm_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                  o_sample_valid,
    output logic                                  o_accepted,
    output logic [asfrm_pkg::FILL_W-1:0]          o_fill_level,
    output logic [asfrm_pkg::ROOT_W-1:0]          o_rms_level,
    output logic                                  o_silent,
    output logic [asfrm_pkg::COUNT_W-1:0]         o_pushed_count,
    output logic [asfrm_pkg::COUNT_W-1:0]         o_popped_count,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [asfrm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [asfrm_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int FW  = asfrm_pkg::FILL_W;
    localparam int SMW = asfrm_pkg::SAMPLE_W;
    localparam int SW  = asfrm_pkg::SUM_W;
    localparam int CW  = asfrm_pkg::COUNT_W;
    localparam int TW  = asfrm_pkg::THR_W;
    localparam int AW  = $clog2(DEPTH);
    // arithmetic width for index wrap and capacity compares
    localparam int EW  = ((AW > FW) ? AW : FW) + 1;
    localparam int MW  = SMW + 1;
    localparam logic [FW-1:0] CAP_MAX =
        (DEPTH > (2 ** FW) - 1) ? {FW{1'b1}} : FW'(DEPTH);
    localparam logic [FW-1:0] CAP_RST =
        (DEPTH < asfrm_pkg::CAP_RESET) ? FW'(DEPTH) : FW'(asfrm_pkg::CAP_RESET);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SUM, S_MEAS, S_DONE} t_state;

    typedef struct packed {
        logic [SMW-1:0]                sample_out;
        logic                          sample_valid;
        logic                          accepted;
        logic [asfrm_pkg::ROOT_W-1:0]  rms;
        logic                          silent;
    } t_item_res;

    typedef struct packed {
        t_item_res     item;
        logic [FW-1:0] fill;
        logic [CW-1:0] pushed;
        logic [CW-1:0] popped;
    } t_out;

    t_state                  r_state;
    logic [asfrm_pkg::CMD_W-1:0] r_cmd;
    logic [AW-1:0]           r_wr_idx;
    logic [AW-1:0]           r_rd_idx;
    logic [FW-1:0]           r_fill;
    logic [SW-1:0]           r_sum;
    logic [CW-1:0]           r_pushed;
    logic [CW-1:0]           r_popped;
    logic                    r_enabled;
    logic                    r_paused;
    logic [FW-1:0]           r_cap;
    logic [TW-1:0]           r_thr;
    logic [31:0]             r_sq;
    t_item_res               r_res;
    t_out                    r_out;
    logic                    r_out_valid;

    logic [SMW-1:0]          r_store [DEPTH];
    logic [SMW-1:0]          r_rdata;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_push_ok;
    logic [EW-1:0]           w_wr_sum;
    logic [EW-1:0]           w_rd_sum;
    logic [EW-1:0]           w_pk_sum;
    logic [AW-1:0]           w_wr_next;
    logic [AW-1:0]           w_rd_next;
    logic [AW-1:0]           w_pk_pos;
    logic [AW-1:0]           w_rd_addr;
    logic                    w_mem_we;
    logic signed [MW-1:0]    w_mul_op;
    logic signed [2*MW-1:0]  w_prod;
    logic [31:0]             w_sq;
    logic [FW-1:0]           n_cap;
    t_item_res               n_res;
    asfrm_pkg::t_rms_req     w_req;
    asfrm_pkg::t_rms_res     w_rms;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_push_ok  = r_enabled && !r_paused && (r_fill < r_cap);

    // index wrap: indices stay below the slot count, offset below the fill
    always_comb begin
        w_wr_sum  = EW'(r_wr_idx) + EW'(1);
        w_rd_sum  = EW'(r_rd_idx) + EW'(1);
        w_pk_sum  = EW'(r_rd_idx) + EW'(i_offset);
        w_wr_next = (w_wr_sum >= EW'(r_cap)) ? '0 : w_wr_sum[AW-1:0];
        w_rd_next = (w_rd_sum >= EW'(r_cap)) ? '0 : w_rd_sum[AW-1:0];
        w_pk_pos  = (w_pk_sum >= EW'(r_cap)) ? AW'(w_pk_sum - EW'(r_cap))
                                             : w_pk_sum[AW-1:0];
        w_rd_addr = (i_command == asfrm_pkg::CMD_PEEK) ? w_pk_pos : r_rd_idx;
        w_mem_we  = w_in_acc && (i_command == asfrm_pkg::CMD_PUSH) && w_push_ok;
    end

    // one shared squarer: incoming sample, threshold, or sample read back
    always_comb begin
        if (r_state == S_IDLE) begin
            if (i_command == asfrm_pkg::CMD_MEASURE) begin
                w_mul_op = signed'({1'b0, r_thr});
            end else begin
                w_mul_op = signed'({i_sample_in[SMW-1], i_sample_in});
            end
        end else begin
            w_mul_op = signed'({r_rdata[SMW-1], r_rdata});
        end
        w_prod = w_mul_op * w_mul_op;
        w_sq   = w_prod[31:0];
    end

    // clamp capacity: zero acts as one slot, anything above the store as the store
    always_comb begin
        if (i_cfg_data[FW-1:0] == '0) begin
            n_cap = FW'(1);
        end else if (EW'(i_cfg_data[FW-1:0]) > EW'(CAP_MAX)) begin
            n_cap = CAP_MAX;
        end else begin
            n_cap = i_cfg_data[FW-1:0];
        end
    end

    // result fields known at accept: push stored, silence of an empty store
    always_comb begin
        n_res          = '0;
        n_res.accepted = (i_command == asfrm_pkg::CMD_PUSH) && w_push_ok;
        n_res.silent   = (i_command == asfrm_pkg::CMD_MEASURE) && (r_fill == '0)
                         && (r_thr != '0);
    end

    always_comb begin
        w_req.start = w_in_acc && (i_command == asfrm_pkg::CMD_MEASURE) && (r_fill != '0);
        w_req.sum   = r_sum;
        w_req.fill  = r_fill;
    end

    asfrm_rms u_rms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_rms)
    );

    // Sample store. Accesses come from separate transactions, so a write always
    // lands at an edge before any read of that entry; no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[r_wr_idx] <= i_sample_in;
        end
        r_rdata <= r_store[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= asfrm_pkg::CMD_PUSH;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_pushed    <= '0;
            r_popped    <= '0;
            r_enabled   <= 1'b0;
            r_paused    <= 1'b0;
            r_cap       <= CAP_RST;
            r_thr       <= '0;
            r_sq        <= '0;
            r_res       <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result when one is ready and the slot is free; drop it once taken
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_command;
                        r_res <= n_res;
                        r_sq  <= w_sq;
                        case (i_command)
                            asfrm_pkg::CMD_PUSH: begin
                                if (w_push_ok) begin
                                    r_wr_idx <= w_wr_next;
                                    r_fill   <= r_fill + 1'b1;
                                    r_pushed <= r_pushed + 1'b1;
                                    r_state  <= S_SUM;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            asfrm_pkg::CMD_POP: begin
                                if (r_fill != '0) begin
                                    r_rd_idx <= w_rd_next;
                                    r_fill   <= r_fill - 1'b1;
                                    r_popped <= r_popped + 1'b1;
                                    r_state  <= S_READ;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            asfrm_pkg::CMD_PEEK: begin
                                if (FW'(i_offset) < r_fill) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            asfrm_pkg::CMD_CLEAR: begin
                                r_wr_idx <= '0;
                                r_rd_idx <= '0;
                                r_fill   <= '0;
                                r_sum    <= '0;
                                r_state  <= S_DONE;
                            end
                            asfrm_pkg::CMD_MEASURE: begin
                                if (r_fill == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_MEAS;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_READ: begin
                    r_res.sample_out   <= r_rdata;
                    r_res.sample_valid <= 1'b1;
                    if (r_cmd == asfrm_pkg::CMD_POP) begin
                        r_sq    <= w_sq;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SUM: begin
                    if (r_cmd == asfrm_pkg::CMD_PUSH) begin
                        r_sum <= r_sum + SW'(r_sq);
                    end else begin
                        r_sum <= r_sum - SW'(r_sq);
                    end
                    r_state <= S_DONE;
                end
                S_MEAS: begin
                    // mean below threshold squared is the same as exact RMS below threshold
                    if (w_rms.done) begin
                        r_res.rms    <= w_rms.root;
                        r_res.silent <= (32'(w_rms.quot) < r_sq);
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.item   <= r_res;
                        r_out.fill   <= r_fill;
                        r_out.pushed <= r_pushed;
                        r_out.popped <= r_popped;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                case (i_cfg_index)
                    asfrm_pkg::CFG_ENABLED:   r_enabled <= i_cfg_data[0];
                    asfrm_pkg::CFG_PAUSED:    r_paused  <= i_cfg_data[0];
                    asfrm_pkg::CFG_CAPACITY: begin
                        r_cap    <= n_cap;
                        r_wr_idx <= '0;
                        r_rd_idx <= '0;
                        r_fill   <= '0;
                        r_sum    <= '0;
                    end
                    asfrm_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = signed'(r_out.item.sample_out);
    assign o_sample_valid = r_out.item.sample_valid;
    assign o_accepted     = r_out.item.accepted;
    assign o_fill_level   = r_out.fill;
    assign o_rms_level    = r_out.item.rms;
    assign o_silent       = r_out.item.silent;
    assign o_pushed_count = r_out.pushed;
    assign o_popped_count = r_out.popped;

endmodule

/* design/asfrm_chk.sv */
module asfrm_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic [asfrm_pkg::CMD_W-1:0]           i_command,
    input logic signed [asfrm_pkg::SAMPLE_W-1:0] i_sample_in,
    input logic [asfrm_pkg::SAMPLE_W-1:0]        i_offset,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [asfrm_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                  o_sample_valid,
    input logic                                  o_accepted,
    input logic [asfrm_pkg::FILL_W-1:0]          o_fill_level,
    input logic [asfrm_pkg::ROOT_W-1:0]          o_rms_level,
    input logic                                  o_silent,
    input logic [asfrm_pkg::COUNT_W-1:0]         o_pushed_count,
    input logic [asfrm_pkg::COUNT_W-1:0]         o_popped_count,
    input logic                                  i_cfg_we,
    input logic [asfrm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [asfrm_pkg::CFG_W-1:0]           i_cfg_data
);

    // one transaction in flight: the input side closes right after a transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a transaction is in flight");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stored push or a nonzero level means samples are held
    a_fill_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_accepted || (o_rms_level != '0))) |-> (o_fill_level != '0))
        else $error("push stored or level reported with an empty store");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sample_out) && $stable(o_fill_level)
             && $stable(o_pushed_count) && $stable(o_popped_count)))
        else $error("stalled result changed");

endmodule

bind audio_sample_fifo_with_rms_meter asfrm_chk u_asfrm_chk (.*);
